// ===== rtl/core/pcbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbt_pkg - shared types and constants for the convex brush point test
// Holds the queue item layout, field widths and reset defaults.
// ----------------------------------------------------------------------------
package pcbt_pkg;

	localparam int MAX_PLANES_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam int CNT_W   = 5;
	localparam int NRM_W   = 18;
	localparam int CRD_W   = 32;
	localparam int IDX_IN_W = 4;

	localparam logic [CNT_W-1:0] PLANE_COUNT_RST = 5'd6;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_TEST = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [IDX_IN_W-1:0]       plane_index;
		logic signed [NRM_W-1:0]   normal_x;
		logic signed [NRM_W-1:0]   normal_y;
		logic signed [NRM_W-1:0]   normal_z;
		logic signed [CRD_W-1:0]   plane_distance;
		logic signed [CRD_W-1:0]   coord_x;
		logic signed [CRD_W-1:0]   coord_y;
		logic signed [CRD_W-1:0]   coord_z;
		logic                      last_vertex;
	} item_t;

endpackage

// ===== rtl/core/pcbt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbt_front - input side of the convex brush point test
// Unpacks the stream item, classifies it and drops loads outside the table.
// ----------------------------------------------------------------------------
module pcbt_front #(
	parameter int MAX_PLANES = pcbt_pkg::MAX_PLANES_DEF
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [191:0]         s_tdata,
	input  logic                 s_tuser,
	input  logic                 s_tlast,
	input  logic                 q_full,
	output logic                 push,
	output pcbt_pkg::item_t      push_item
);

	logic load_ok;

	always_comb begin
		push_item.kind           = s_tuser ? pcbt_pkg::KIND_TEST : pcbt_pkg::KIND_LOAD;
		push_item.plane_index    = s_tdata[3:0];
		push_item.normal_x       = s_tdata[21:4];
		push_item.normal_y       = s_tdata[39:22];
		push_item.normal_z       = s_tdata[57:40];
		push_item.plane_distance = s_tdata[89:58];
		push_item.coord_x        = s_tdata[121:90];
		push_item.coord_y        = s_tdata[153:122];
		push_item.coord_z        = s_tdata[185:154];
		push_item.last_vertex    = s_tlast;
	end

	// drop loads aimed past the end of the table
	assign load_ok  = (32'(s_tdata[3:0]) < MAX_PLANES);
	assign s_tready = ~q_full;
	assign push     = s_tvalid & ~q_full &
		((push_item.kind == pcbt_pkg::KIND_TEST) | load_ok);

endmodule

// ===== rtl/core/pcbt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbt_queue - short item queue between front and back
// Register-based FIFO; head is visible without a pop.
// ----------------------------------------------------------------------------
module pcbt_queue #(
	parameter int DEPTH = pcbt_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcbt_pkg::item_t  push_item,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output pcbt_pkg::item_t  head_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pcbt_pkg::item_t  mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= CW'(count_q + 1'b1);
				2'b01:   count_q <= CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/pcbt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbt_back - plane table and half-space test engine
// Writes plane loads into the table and walks each vertex over the planes.
// ----------------------------------------------------------------------------
module pcbt_back #(
	parameter int MAX_PLANES = pcbt_pkg::MAX_PLANES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pcbt_pkg::CNT_W-1:0]  plane_count,
	input  logic                        q_valid,
	input  pcbt_pkg::item_t             q_item,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [103:0]                m_tdata,
	output logic                        m_tlast
);

	localparam int IDXW = $clog2(MAX_PLANES);
	localparam int KW   = $clog2(MAX_PLANES + 1);
	localparam int NW   = pcbt_pkg::NRM_W;
	localparam int DW   = pcbt_pkg::CRD_W;
	localparam int PRW  = DW + NW;
	localparam int SW   = PRW + 2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic signed [NW-1:0] nx_mem [MAX_PLANES];
	logic signed [NW-1:0] ny_mem [MAX_PLANES];
	logic signed [NW-1:0] nz_mem [MAX_PLANES];
	logic signed [DW-1:0] d_mem  [MAX_PLANES];

	logic [KW-1:0]         k_q;
	logic [KW-1:0]         n_eff;
	logic                  v_s1;
	logic                  v_s2;
	logic                  inside_q;
	logic                  found_q;
	logic                  last_q;
	logic signed [DW-1:0]  cx_q;
	logic signed [DW-1:0]  cy_q;
	logic signed [DW-1:0]  cz_q;

	logic signed [NW-1:0]  nx_s1;
	logic signed [NW-1:0]  ny_s1;
	logic signed [NW-1:0]  nz_s1;
	logic signed [DW-1:0]  d_s1;
	logic signed [PRW-1:0] px_s2;
	logic signed [PRW-1:0] py_s2;
	logic signed [PRW-1:0] pz_s2;
	logic signed [DW-1:0]  d_s2;

	logic signed [SW-1:0]  dot;
	logic signed [SW-1:0]  d_scaled;
	logic                  below;
	logic                  is_load;
	logic                  is_test;
	logic                  out_free;
	logic                  last_issue;
	logic                  m_tvalid_q;
	logic [103:0]          m_tdata_q;
	logic                  m_tlast_q;

	// clamp the count to the table size
	assign n_eff = (32'(plane_count) > MAX_PLANES) ? KW'(MAX_PLANES) : KW'(plane_count);

	assign q_pop      = (state_q == ST_IDLE) & q_valid;
	assign is_load    = q_pop & (q_item.kind == pcbt_pkg::KIND_LOAD);
	assign is_test    = q_pop & (q_item.kind == pcbt_pkg::KIND_TEST);
	assign out_free   = ~m_tvalid_q | m_tready;
	assign last_issue = (KW'(k_q + 1'b1) == n_eff);

	assign dot      = SW'(px_s2) + SW'(py_s2) + SW'(pz_s2);
	assign d_scaled = SW'($signed({d_s2, 16'h0000}));
	assign below    = (dot < d_scaled);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// table write on load, registered read while running
	always_ff @(posedge clk) begin
		if (is_load) begin
			nx_mem[IDXW'(q_item.plane_index)] <= q_item.normal_x;
			ny_mem[IDXW'(q_item.plane_index)] <= q_item.normal_y;
			nz_mem[IDXW'(q_item.plane_index)] <= q_item.normal_z;
			d_mem[IDXW'(q_item.plane_index)]  <= q_item.plane_distance;
		end
		nx_s1 <= nx_mem[k_q[IDXW-1:0]];
		ny_s1 <= ny_mem[k_q[IDXW-1:0]];
		nz_s1 <= nz_mem[k_q[IDXW-1:0]];
		d_s1  <= d_mem[k_q[IDXW-1:0]];
	end

	always_ff @(posedge clk) begin
		px_s2 <= cx_q * nx_s1;
		py_s2 <= cy_q * ny_s1;
		pz_s2 <= cz_q * nz_s1;
		d_s2  <= d_s1;
		if (is_test) begin
			cx_q   <= q_item.coord_x;
			cy_q   <= q_item.coord_y;
			cz_q   <= q_item.coord_z;
			last_q <= q_item.last_vertex;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {6'b0, cz_q, cy_q, cx_q, inside_q & ~found_q, inside_q};
			m_tlast_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			inside_q   <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			if (v_s2 && !below) begin
				inside_q <= 1'b0;
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (is_test) begin
						k_q      <= '0;
						inside_q <= 1'b1;
						state_q  <= (n_eff == '0) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					k_q <= KW'(k_q + 1'b1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						found_q <= last_q ? 1'b0 : (found_q | inside_q);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/point_in_convex_brush_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_brush_test_top - vertex against convex brush planes
// Loads a plane table and tests vertices against its first planes.
// ----------------------------------------------------------------------------
// A plane load item (tuser 0) writes one normal and distance into the table
// slot given by plane_index; loads to a slot at or past MAX_PLANES are dropped.
// A vertex item (tuser 1) is tested against the first plane_count planes
// (clamped to MAX_PLANES) and yields one result: inside when the exact
// 52-bit dot product with every normal is strictly below that plane's
// distance in Q.32 scale. first_hit marks the first inside vertex of a set;
// tlast on the vertex ends the set and comes back as tlast on its result.
// A vertex is walked by the single table read port, which feeds one plane
// per cycle into the multiply and compare stages; no further item is
// popped until its result is registered. A two-entry queue lets new items
// arrive while a vertex is being walked, and the output register holds a
// result until it is taken. Table slots must be loaded before a vertex
// reads them. Write plane_count only while the block is idle.
// ----------------------------------------------------------------------------
module point_in_convex_brush_test_top #(
	parameter int MAX_PLANES  = pcbt_pkg::MAX_PLANES_DEF,
	parameter int QUEUE_DEPTH = pcbt_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	// plane_count register
	input  logic          cfg_we,
	input  logic [4:0]    cfg_data,
	// input items
	input  logic          s_tvalid,
	output logic          s_tready,
	// plane_index[3:0], normal_x[21:4], normal_y[39:22], normal_z[57:40],
	// plane_distance[89:58], coord_x[121:90], coord_y[153:122],
	// coord_z[185:154], zero fill
	input  logic [191:0]  s_tdata,
	// operation: 0 load plane, 1 test vertex
	input  logic          s_tuser,
	// last_vertex
	input  logic          s_tlast,
	// result items
	output logic          m_tvalid,
	input  logic          m_tready,
	// inside_res[0], first_hit[1], hit_x[33:2], hit_y[65:34], hit_z[97:66],
	// zero fill
	output logic [103:0]  m_tdata,
	// set_end
	output logic          m_tlast
);

	logic [pcbt_pkg::CNT_W-1:0] plane_count_q;
	logic                       push;
	pcbt_pkg::item_t            push_item;
	logic                       q_full;
	logic                       q_pop;
	logic                       q_valid;
	pcbt_pkg::item_t            q_item;

	// hold the plane count until rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= pcbt_pkg::PLANE_COUNT_RST;
		end else if (cfg_we) begin
			plane_count_q <= cfg_data;
		end
	end

	// classify incoming items and drop out-of-table loads
	pcbt_front #(
		.MAX_PLANES (MAX_PLANES)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decouple intake from the plane walk
	pcbt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_item)
	);

	// table writes, plane walk and result register
	pcbt_back #(
		.MAX_PLANES (MAX_PLANES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.plane_count (plane_count_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

// ===== tb/point_in_convex_brush_test_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_brush_test_top_test - self-checking bench for the brush test
// Streams plane loads and vertex sets into the block, predicts each contact
// result from a local copy of the plane table, and compares field by field.
// ----------------------------------------------------------------------------
// Flow: a short directed run at the reset plane count, then phases that each
// rewrite plane_count while idle (zero, saturating, full table, single plane,
// then random), reload all sixteen planes as a box plus loose extra planes
// around a random half size, and send vertex sets scattered around that box.
// Noise planes, noise vertices and mid-stream plane rewrites are mixed in.
// The sender runs in bursts with gaps, the receiver stalls on its own
// patterns, and once the receiver holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module point_in_convex_brush_test_top_test;

	localparam int ITEM_TARGET   = 1950;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int DIR_HALF      = 1 << 20;	// 16.0 in Q16.16
	localparam logic signed [pcbt_pkg::NRM_W-1:0] UNIT = 18'sd65536;	// 1.0 in Q1.16

	typedef struct {
		logic        in_brush;
		logic        first;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        set_end;
	} contact_t;

	logic          clk;
	logic          arst_n   = 1'b0;
	logic          cfg_we   = 1'b0;
	logic [4:0]    cfg_data = '0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [191:0]  s_tdata  = '0;
	logic          s_tuser  = 1'b0;
	logic          s_tlast  = 1'b0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [103:0]  m_tdata;
	logic          m_tlast;

	// Predictor state: plane table, set tracking and the register copy
	logic signed [pcbt_pkg::NRM_W-1:0] brush_nx [pcbt_pkg::MAX_PLANES_DEF];
	logic signed [pcbt_pkg::NRM_W-1:0] brush_ny [pcbt_pkg::MAX_PLANES_DEF];
	logic signed [pcbt_pkg::NRM_W-1:0] brush_nz [pcbt_pkg::MAX_PLANES_DEF];
	logic signed [pcbt_pkg::CRD_W-1:0] brush_dist [pcbt_pkg::MAX_PLANES_DEF];
	logic                              hit_in_set = 1'b0;
	logic [pcbt_pkg::CNT_W-1:0]        plane_cnt  = pcbt_pkg::PLANE_COUNT_RST;

	pcbt_pkg::item_t items_to_send [$];
	contact_t        contacts_due [$];
	pcbt_pkg::item_t drv_item;
	logic     in_fire    = 1'b0;
	int       n_in       = 0;
	int       n_queued   = 0;
	int       errors     = 0;
	int       cycles     = 0;
	int       burst_left = 1;
	int       gap_left   = 0;
	logic     hold_off   = 1'b0;
	logic [1:0] rx_mode  = '0;
	int       rx_left    = 0;
	logic [7:0] rx_mask  = '1;
	logic [2:0] rx_phase = '0;

	point_in_convex_brush_test_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Update the plane table on a load; on a vertex, test every active plane
	// with the exact 64-bit dot product and queue the contact it must yield.
	task automatic apply_item(input pcbt_pkg::item_t it);
		int       n;
		logic     in_brush;
		longint   dot;
		contact_t c;
		if (it.kind == pcbt_pkg::KIND_LOAD) begin
			if (it.plane_index < pcbt_pkg::MAX_PLANES_DEF) begin
				brush_nx[it.plane_index]   = it.normal_x;
				brush_ny[it.plane_index]   = it.normal_y;
				brush_nz[it.plane_index]   = it.normal_z;
				brush_dist[it.plane_index] = it.plane_distance;
			end
		end else begin
			n = (plane_cnt > pcbt_pkg::MAX_PLANES_DEF) ? pcbt_pkg::MAX_PLANES_DEF : plane_cnt;
			in_brush = 1'b1;
			for (int k = 0; k < n; k++) begin
				dot = longint'($signed(it.coord_x)) * longint'($signed(brush_nx[k])) +
				      longint'($signed(it.coord_y)) * longint'($signed(brush_ny[k])) +
				      longint'($signed(it.coord_z)) * longint'($signed(brush_nz[k]));
				// strict test: a vertex on the plane counts as outside
				if (dot >= longint'($signed(brush_dist[k])) * 64'sd65536)
					in_brush = 1'b0;
			end
			c.in_brush = in_brush;
			c.first    = in_brush && !hit_in_set;
			c.x        = it.coord_x;
			c.y        = it.coord_y;
			c.z        = it.coord_z;
			c.set_end  = it.last_vertex;
			contacts_due.push_back(c);
			if (in_brush)
				hit_in_set = 1'b1;
			if (it.last_vertex)
				hit_in_set = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	function automatic pcbt_pkg::item_t plane(input int idx,
			input logic signed [pcbt_pkg::NRM_W-1:0] nx,
			input logic signed [pcbt_pkg::NRM_W-1:0] ny,
			input logic signed [pcbt_pkg::NRM_W-1:0] nz,
			input logic signed [pcbt_pkg::CRD_W-1:0] plane_d, input logic last);
		pcbt_pkg::item_t p;
		p = '0;
		p.kind           = pcbt_pkg::KIND_LOAD;
		p.plane_index    = idx[pcbt_pkg::IDX_IN_W-1:0];
		p.normal_x       = nx;
		p.normal_y       = ny;
		p.normal_z       = nz;
		p.plane_distance = plane_d;
		p.last_vertex    = last;
		return p;
	endfunction

	function automatic pcbt_pkg::item_t vertex(input logic signed [pcbt_pkg::CRD_W-1:0] x,
			input logic signed [pcbt_pkg::CRD_W-1:0] y,
			input logic signed [pcbt_pkg::CRD_W-1:0] z, input logic last);
		pcbt_pkg::item_t v;
		v = '0;
		v.kind        = pcbt_pkg::KIND_TEST;
		v.coord_x     = x;
		v.coord_y     = y;
		v.coord_z     = z;
		v.last_vertex = last;
		return v;
	endfunction

	// Slots 0..5 form an axis box of the given half size, the rest are loose
	// planes that cut only some of the box; now and then any bit pattern.
	function automatic pcbt_pkg::item_t make_plane(input int slot, input int half);
		logic signed [pcbt_pkg::NRM_W-1:0] n [3];
		logic signed [pcbt_pkg::CRD_W-1:0] plane_d;
		if ($urandom_range(0, 11) == 0) begin
			for (int a = 0; a < 3; a++)
				n[a] = pcbt_pkg::NRM_W'($urandom);
			plane_d = $urandom;
		end else if (slot < 6) begin
			for (int a = 0; a < 3; a++)
				n[a] = '0;
			n[slot / 2] = (slot % 2) ? -UNIT : UNIT;
			plane_d = half;
		end else begin
			for (int a = 0; a < 3; a++)
				n[a] = pcbt_pkg::NRM_W'($urandom_range(0, 131072) - 65536);
			plane_d = $urandom_range(half, 3 * half);
		end
		return plane(slot, n[0], n[1], n[2], plane_d, $urandom_range(0, 7) == 0);
	endfunction

	// Scatter vertices around the box, some exactly on a face, a few anywhere
	function automatic pcbt_pkg::item_t make_vertex(input int half, input logic last);
		int span;
		int sel;
		int axis;
		logic signed [pcbt_pkg::CRD_W-1:0] c [3];
		span = half + half / 2;
		sel  = $urandom_range(0, 15);
		for (int a = 0; a < 3; a++)
			c[a] = (sel == 0) ? $urandom : $urandom_range(0, 2 * span) - span;
		if (sel == 1) begin
			axis = $urandom_range(0, 2);
			c[axis] = $urandom_range(0, 1) ? half : -half;
		end
		return vertex(c[0], c[1], c[2], last);
	endfunction

	task automatic queue_item(input pcbt_pkg::item_t it);
		items_to_send.push_back(it);
		n_queued++;
	endtask

	// Hold until nothing is in flight, then let trailing loads drain
	task automatic wait_idle();
		while (items_to_send.size() != 0 || s_tvalid || contacts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_plane_count(input logic [pcbt_pkg::CNT_W-1:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		plane_cnt = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [pcbt_pkg::CNT_W-1:0] count);
		int half;
		int order [16];
		int j;
		int tmp;
		int set_left;
		wait_idle();
		set_plane_count(count);
		half = $urandom_range(1 << 16, 1 << 22);
		for (int s = 0; s < 16; s++)
			order[s] = s;
		for (int s = 0; s < 16; s++) begin
			j = $urandom_range(0, 15);
			tmp = order[s];
			order[s] = order[j];
			order[j] = tmp;
		end
		// every slot is written before the first vertex of the phase
		for (int s = 0; s < 16; s++)
			queue_item(make_plane(order[s], half));
		set_left = $urandom_range(1, 6);
		repeat ($urandom_range(40, 160)) begin
			// rewrite a plane now and then while vertices are queued
			if ($urandom_range(0, 15) == 0)
				queue_item(make_plane($urandom_range(0, 15), half));
			set_left--;
			queue_item(make_vertex(half, set_left == 0));
			if (set_left == 0)
				set_left = $urandom_range(1, 6);
		end
	endtask

	initial begin : stimulus
		logic [pcbt_pkg::CNT_W-1:0] count_plan [$];
		logic [pcbt_pkg::CNT_W-1:0] count;
		count_plan = '{5'd0, 5'd31, 5'd16, 5'd1};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed run at the reset plane count: a box of half size 16.0
		queue_item(plane(0, UNIT, 0, 0, DIR_HALF, 1'b0));
		queue_item(plane(1, -UNIT, 0, 0, DIR_HALF, 1'b0));
		queue_item(plane(2, 0, UNIT, 0, DIR_HALF, 1'b0));
		queue_item(plane(3, 0, -UNIT, 0, DIR_HALF, 1'b0));
		queue_item(plane(4, 0, 0, UNIT, DIR_HALF, 1'b0));
		queue_item(plane(5, 0, 0, -UNIT, DIR_HALF, 1'b0));
		// normals past +-1.0 and the distance extremes; last marker on a load
		queue_item(plane(6, 18'sh1ffff, 18'sh20000, 0, 32'sh7fffffff, 1'b0));
		queue_item(plane(15, -UNIT, UNIT, -UNIT, 32'sh80000000, 1'b1));
		queue_item(vertex(0, 0, 0, 1'b0));
		queue_item(vertex(DIR_HALF - 1, 0, 0, 1'b0));
		queue_item(vertex(DIR_HALF, 0, 0, 1'b0));	// on a face: outside
		queue_item(vertex(0, -DIR_HALF, 0, 1'b0));
		queue_item(vertex(0, 0, 1 - DIR_HALF, 1'b0));
		queue_item(vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
		queue_item(vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1));
		queue_item(vertex(DIR_HALF, DIR_HALF, DIR_HALF, 1'b0));
		queue_item(vertex(1, -1, 1, 1'b1));
		queue_item(vertex(0, 0, 0, 1'b1));	// one-vertex set
		queue_item(plane(0, UNIT, 0, 0, 0, 1'b0));	// face through the origin
		queue_item(vertex(0, 0, 0, 1'b0));
		queue_item(vertex(-1, 0, 0, 1'b1));

		// Register extremes first, then mostly in-range random counts
		while (n_queued < ITEM_TARGET) begin
			if (count_plan.size() != 0)
				count = count_plan.pop_front();
			else if ($urandom_range(0, 7) == 0)
				count = pcbt_pkg::CNT_W'($urandom_range(0, 31));
			else
				count = pcbt_pkg::CNT_W'($urandom_range(1, 16));
			run_phase(count);
		end

		wait_idle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Sender: advance on acceptance, in bursts separated by random gaps
	always @(negedge clk) begin : drive_items
		pcbt_pkg::item_t nxt;
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (items_to_send.size() != 0) begin
				nxt = items_to_send.pop_front();
				drv_item <= nxt;
				s_tdata  <= {6'd0, nxt.coord_z, nxt.coord_y, nxt.coord_x,
				             nxt.plane_distance, nxt.normal_z, nxt.normal_y,
				             nxt.normal_x, nxt.plane_index};
				s_tuser  <= nxt.kind;
				s_tlast  <= nxt.last_vertex;
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 32);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switch among always ready, coin flip, a repeating mask and
	// mostly stalled, each for a random stretch
	always @(negedge clk) begin : drive_ready
		if (rx_left == 0) begin
			rx_mode <= 2'($urandom_range(0, 3));
			rx_left <= $urandom_range(64, 512);
			rx_mask <= 8'($urandom);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_phase <= rx_phase + 3'd1;
		case (rx_mode)
			2'd0: begin
				m_tready <= !hold_off;
			end
			2'd1: begin
				m_tready <= !hold_off && ($urandom_range(0, 1) == 1);
			end
			2'd2: begin
				m_tready <= !hold_off && rx_mask[rx_phase];
			end
			default: begin
				m_tready <= !hold_off && ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Hold off the receiver once while a backlog is still being offered
	initial begin : long_hold
		while (n_in < 300 || items_to_send.size() < 8)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin : take_inputs
		if (arst_n && s_tvalid && s_tready) begin
			apply_item(drv_item);
			n_in    <= n_in + 1;
			in_fire <= 1'b1;
		end else begin
			in_fire <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		contact_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (contacts_due.size() == 0) begin
				$error("result item arrived with none expected");
				errors++;
			end else begin
				want = contacts_due.pop_front();
				check_field("inside_res", 32'(want.in_brush), 32'(m_tdata[0]));
				check_field("first_hit", 32'(want.first), 32'(m_tdata[1]));
				check_field("hit_x", want.x, m_tdata[33:2]);
				check_field("hit_y", want.y, m_tdata[65:34]);
				check_field("hit_z", want.z, m_tdata[97:66]);
				check_field("set_end", 32'(want.set_end), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
